// ----- src/api_frame_receiver_macros.svh -----
// Assertion macros shared by the frame receiver RTL.
// Depends on nothing; users must provide signals named clock and reset.
`ifndef API_FRAME_RECEIVER_MACROS_SVH
`define API_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define AFR_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("api_frame_receiver: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define AFR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("api_frame_receiver: assertion failed");

`endif

// ----- src/afr_pkg.sv -----
// Package for the API frame receiver: field widths, codes and constants.
// Used by the channel interfaces and the top level; depends on nothing.
`default_nettype none

package afr_pkg;

   localparam int CMD_W    = 1;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 6;
   localparam int LENGTH_W = 16;
   localparam int TICKS_W  = 16;

   localparam logic [CMD_W-1:0] CMD_BYTE = 1'b0;
   localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

   localparam logic [BYTE_W-1:0]   START_BYTE    = 8'h7E;
   localparam logic [BYTE_W-1:0]   CHECK_BASE    = 8'hFF;
   localparam logic [TICKS_W-1:0]  TIMEOUT_RESET = 16'd150;
   localparam logic [TICKS_W-1:0]  IDLE_MAX      = 16'hFFFF;

   localparam int BUFFER_DEPTH_DEFAULT = 16;

endpackage

`default_nettype wire

// ----- src/afr_if.sv -----
// Valid/ready channel interfaces for the API frame receiver.
// Depends on afr_pkg for the field widths.
`default_nettype none

interface afr_req_if
   import afr_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output cmd, output rx_byte, input ready);
   modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface afr_rsp_if
   import afr_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [BYTE_W-1:0]   payload_byte;
   logic [INDEX_W-1:0]  byte_index;
   logic [LENGTH_W-1:0] frame_length;
   logic                truncated;
   logic                last;

   modport source (output valid, output payload_byte, output byte_index,
                   output frame_length, output truncated, output last, input ready);
   modport sink   (input valid, input payload_byte, input byte_index,
                   input frame_length, input truncated, input last, output ready);
endinterface

`default_nettype wire

// ----- src/afr_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none

module afr_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/api_frame_receiver.sv -----
// Top level of the API frame receiver: framing, checksum and payload replay.
// Depends on afr_pkg, afr_if.sv, afr_ram.sv and api_frame_receiver_macros.svh.
//
//   channel    direction  handshake          word
//   req_chan   in         valid/ready        cmd, rx_byte
//   rsp_chan   out        valid/ready        payload_byte, byte_index,
//                                            frame_length, truncated, last
//   csr_*      in         write enable only  timeout_ticks
//
// While a frame is being received, one word is taken every cycle.
// After a good checksum the stored payload is replayed from the payload RAM:
// each result is read from the RAM, then presented and held while the sink stalls.
// The input is held off during replay, so the RAM is never read and written at once.
// Reset is synchronous and returns to hunting with timeout_ticks at 150.
`default_nettype none

`include "api_frame_receiver_macros.svh"

module api_frame_receiver
   import afr_pkg::*;
#(
   parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wen,
   input  wire logic [TICKS_W-1:0] csr_wdata,
   afr_req_if.sink                 req_chan,
   afr_rsp_if.source               rsp_chan
);

   localparam int IW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [LENGTH_W-1:0] DEPTH_LEN = LENGTH_W'(BUFFER_DEPTH);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_MSB,
      PH_LSB,
      PH_DATA
   } phase_type;

   typedef enum logic [1:0] {
      ST_RUN,
      ST_FETCH,
      ST_SHOW
   } state_type;

   state_type           state_ff, state_in;
   phase_type           phase_ff, phase_in;
   logic [TICKS_W-1:0]  timeout_ff, timeout_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic [LENGTH_W-1:0] taken_ff, taken_in;
   logic [BYTE_W-1:0]   sum_ff, sum_in;
   logic [TICKS_W-1:0]  idle_ff, idle_in;
   logic [IW-1:0]       play_idx_ff, play_idx_in;
   logic [IW-1:0]       play_last_ff, play_last_in;
   logic                empty_ff, empty_in;

   logic                accept;
   logic                is_tick;
   logic                ram_wr_en;
   logic                ram_rd_en;
   logic [BYTE_W-1:0]   ram_rd_data;
   logic                too_long;
   logic [TICKS_W-1:0]  idle_inc;

   assign accept   = req_chan.valid && req_chan.ready;
   assign is_tick  = (req_chan.cmd == CMD_TICK);
   assign too_long = (length_ff > DEPTH_LEN);
   assign idle_inc = (idle_ff == IDLE_MAX) ? idle_ff : idle_ff + 16'd1;

   assign req_chan.ready = (state_ff == ST_RUN);

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      timeout_in   = timeout_ff;
      length_in    = length_ff;
      taken_in     = taken_ff;
      sum_in       = sum_ff;
      idle_in      = idle_ff;
      play_idx_in  = play_idx_ff;
      play_last_in = play_last_ff;
      empty_in     = empty_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;

      if (csr_wen) begin
         timeout_in = csr_wdata;
      end

      case (state_ff)
         ST_RUN: begin
            if (accept && is_tick) begin
               if (phase_ff != PH_HUNT) begin
                  idle_in = idle_inc;
                  // A zero timeout fires on the first tick, like a timeout of one.
                  if (idle_inc >= timeout_ff) begin
                     phase_in = PH_HUNT;
                     taken_in = '0;
                     sum_in   = '0;
                  end
               end
            end else if (accept) begin
               case (phase_ff)
                  PH_HUNT: begin
                     if (req_chan.rx_byte == START_BYTE) begin
                        phase_in = PH_MSB;
                        idle_in  = '0;
                        taken_in = '0;
                        sum_in   = '0;
                     end
                  end
                  PH_MSB: begin
                     length_in = {req_chan.rx_byte, 8'h00};
                     idle_in   = '0;
                     phase_in  = PH_LSB;
                  end
                  PH_LSB: begin
                     length_in = {length_ff[15:8], req_chan.rx_byte};
                     idle_in   = '0;
                     phase_in  = PH_DATA;
                  end
                  PH_DATA: begin
                     idle_in = '0;
                     if (taken_ff < length_ff) begin
                        // Bytes past the buffer still count toward the checksum.
                        ram_wr_en = (taken_ff < DEPTH_LEN);
                        sum_in    = sum_ff + req_chan.rx_byte;
                        taken_in  = taken_ff + 16'd1;
                     end else begin
                        phase_in = PH_HUNT;
                        taken_in = '0;
                        sum_in   = '0;
                        if (req_chan.rx_byte == CHECK_BASE - sum_ff) begin
                           play_idx_in = '0;
                           if (length_ff == '0) begin
                              empty_in = 1'b1;
                              state_in = ST_SHOW;
                           end else begin
                              empty_in     = 1'b0;
                              play_last_in = too_long ? IW'(BUFFER_DEPTH - 1)
                                                      : IW'(length_ff - 16'd1);
                              state_in     = ST_FETCH;
                           end
                        end
                     end
                  end
                  default: begin
                     phase_in = PH_HUNT;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            ram_rd_en = 1'b1;
            state_in  = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_chan.ready) begin
               if (empty_ff || play_idx_ff == play_last_ff) begin
                  state_in = ST_RUN;
               end else begin
                  play_idx_in = play_idx_ff + IW'(1);
                  state_in    = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_RUN;
         phase_ff   <= PH_HUNT;
         timeout_ff <= TIMEOUT_RESET;
         length_ff  <= '0;
         taken_ff   <= '0;
         sum_ff     <= '0;
         idle_ff    <= '0;
         empty_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         timeout_ff <= timeout_in;
         length_ff  <= length_in;
         taken_ff   <= taken_in;
         sum_ff     <= sum_in;
         idle_ff    <= idle_in;
         empty_ff   <= empty_in;
      end
      play_idx_ff  <= play_idx_in;
      play_last_ff <= play_last_in;
   end

   afr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (taken_ff[IW-1:0]),
      .wr_data (req_chan.rx_byte),
      .rd_en   (ram_rd_en),
      .rd_addr (play_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_chan.valid        = (state_ff == ST_SHOW);
   assign rsp_chan.payload_byte = empty_ff ? '0 : ram_rd_data;
   assign rsp_chan.byte_index   = INDEX_W'(play_idx_ff);
   assign rsp_chan.frame_length = length_ff;
   assign rsp_chan.truncated    = too_long;
   assign rsp_chan.last         = empty_ff || (play_idx_ff == play_last_ff);

   // An empty frame gives exactly one all-zero word marked last.
   `AFR_ASSERT_IMPL(a_empty_word, rsp_chan.valid && rsp_chan.frame_length == '0,
      rsp_chan.last && rsp_chan.payload_byte == '0 && rsp_chan.byte_index == '0)

   // The final word of a frame that fits the buffer sits at the length minus one.
   `AFR_ASSERT_IMPL(a_last_index,
      rsp_chan.valid && rsp_chan.last && !rsp_chan.truncated && rsp_chan.frame_length != '0,
      LENGTH_W'(rsp_chan.byte_index) == rsp_chan.frame_length - 16'd1)

   // Once the last word is taken the block takes input again.
   `AFR_ASSERT_NEXT(a_resume, rsp_chan.valid && rsp_chan.ready && rsp_chan.last,
      req_chan.ready)

   // A tick never starts a frame.
   `AFR_ASSERT_NEXT(a_tick_hunt, accept && is_tick && phase_ff == PH_HUNT,
      phase_ff == PH_HUNT)

endmodule

`default_nettype wire

// ----- tb/afr_frame_checker.sv -----
// Scoreboard for the API frame receiver: follows the framing state from the words
// that the block accepts and compares every replayed payload word with its prediction.
// Depends on afr_pkg and the channel interfaces in afr_if.sv.
`timescale 1ns / 100ps

module afr_frame_checker
   import afr_pkg::*;
#(
   parameter int DEPTH = BUFFER_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_wen,
   input  wire logic [TICKS_W-1:0] csr_wdata,
   afr_req_if                      req_mon,
   afr_rsp_if                      rsp_mon,
   output int                      mismatches,
   output int                      pending
);

   typedef enum logic [1:0] {HUNT, LEN_HI, LEN_LO, BODY} rx_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   payload_byte;
      logic [INDEX_W-1:0]  byte_index;
      logic [LENGTH_W-1:0] frame_length;
      logic                truncated;
      logic                last;
   } payload_word_type;

   rx_phase_type        phase;
   logic [TICKS_W-1:0]  timeout;
   logic [LENGTH_W-1:0] length;
   logic [LENGTH_W-1:0] taken;
   logic [BYTE_W-1:0]   sum;
   logic [TICKS_W-1:0]  idle;
   logic [BYTE_W-1:0]   store [DEPTH];
   payload_word_type    replay_due [$];

   task automatic drop_frame();
      phase = HUNT;
      taken = '0;
      sum = '0;
   endtask

   task automatic queue_replay(input logic [BYTE_W-1:0] b, input int idx, input logic trunc,
                               input logic fin);
      payload_word_type w;
      w.payload_byte = b;
      w.byte_index = idx[INDEX_W-1:0];
      w.frame_length = length;
      w.truncated = trunc;
      w.last = fin;
      replay_due.push_back(w);
   endtask

   // Advances the framing state by one accepted word and queues any replay it triggers.
   task automatic track_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] want_check;
      logic              trunc;
      int                count;
      int                i;
      if (cmd == CMD_TICK) begin
         if (phase != HUNT) begin
            if (idle != IDLE_MAX) idle = idle + 16'd1;
            if (idle >= timeout) drop_frame();
         end
      end else begin
         case (phase)
            HUNT: begin
               if (b == START_BYTE) begin
                  phase = LEN_HI;
                  idle = '0;
                  taken = '0;
                  sum = '0;
               end
            end
            LEN_HI: begin
               length = {b, 8'h00};
               idle = '0;
               phase = LEN_LO;
            end
            LEN_LO: begin
               length[7:0] = b;
               idle = '0;
               phase = BODY;
            end
            default: begin
               idle = '0;
               if (taken < length) begin
                  if (taken < DEPTH) store[taken] = b;
                  sum = sum + b;
                  taken = taken + 16'd1;
               end else begin
                  want_check = CHECK_BASE - sum;
                  drop_frame();
                  if (want_check == b) begin
                     if (length == 0) begin
                        queue_replay('0, 0, 1'b0, 1'b1);
                     end else begin
                        trunc = (length > DEPTH);
                        count = trunc ? DEPTH : int'(length);
                        for (i = 0; i < count; i++)
                           queue_replay(store[i], i, trunc, i + 1 == count);
                     end
                  end
               end
            end
         endcase
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      payload_word_type want;
      if (reset) begin
         phase = HUNT;
         timeout = TIMEOUT_RESET;
         length = '0;
         taken = '0;
         sum = '0;
         idle = '0;
         mismatches = 0;
         replay_due.delete();
      end else begin
         if (csr_wen) timeout = csr_wdata;
         // Results are checked before the input word of the same edge is absorbed,
         // since a word can never be replayed on the edge that completes its frame.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (replay_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected word, expected none, actual byte %0h index %0d",
                        $time, rsp_mon.payload_byte, rsp_mon.byte_index);
            end else begin
               want = replay_due.pop_front();
               check_field("payload_byte", int'(want.payload_byte),
                           int'(rsp_mon.payload_byte));
               check_field("byte_index", int'(want.byte_index), int'(rsp_mon.byte_index));
               check_field("frame_length", int'(want.frame_length),
                           int'(rsp_mon.frame_length));
               check_field("truncated", int'(want.truncated), int'(rsp_mon.truncated));
               check_field("last", int'(want.last), int'(rsp_mon.last));
            end
         end
         if (req_mon.valid && req_mon.ready) track_word(req_mon.cmd, req_mon.rx_byte);
      end
      pending = replay_due.size();
   end

endmodule

// ----- tb/api_frame_receiver_test.sv -----
// Top of the frame receiver testbench: clock, reset, byte and tick stimulus,
// timeout register writes and the verdict. Depends on afr_pkg, afr_if.sv,
// api_frame_receiver and afr_frame_checker.
`timescale 1ns / 100ps

module api_frame_receiver_test;
   import afr_pkg::*;

   localparam int FILL_RANDOM = 0;
   localparam int FILL_ZERO   = 1;
   localparam int FILL_ONES   = 2;
   localparam int FILL_START  = 3;

   localparam logic [TICKS_W-1:0] SHORT_TIMEOUT = 16'd6;

   logic               clock;
   logic               reset;
   logic               csr_wen;
   logic [TICKS_W-1:0] csr_wdata;
   logic               calm;
   int                 cur_timeout;
   int                 frame_words;
   int                 mismatches;
   int                 pending;

   afr_req_if req ();
   afr_rsp_if rsp ();

   api_frame_receiver DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata),
      .req_chan  (req),
      .rsp_chan  (rsp)
   );

   afr_frame_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_mon    (req),
      .rsp_mon    (rsp),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("tb: failure");
      $finish;
   end

   // Sink side: a random stall before each word, none while calm is set.
   initial begin
      int stall;
      rsp.ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 11);
         @(negedge clock);
         if (stall > 0) begin
            rsp.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp.ready = 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   end

   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 11);
      @(negedge clock);
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid = 1'b1;
      req.cmd = cmd;
      req.rx_byte = b;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic send_byte(input logic [BYTE_W-1:0] b);
      send_word(CMD_BYTE, b);
      frame_words++;
   endtask

   task automatic send_tick();
      send_word(CMD_TICK, 8'($urandom));
   endtask

   // A few ticks that stay below the timeout, now and then.
   task automatic safe_ticks();
      int n;
      if (!calm && cur_timeout > 1 && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, (cur_timeout - 1 < 5) ? cur_timeout - 1 : 5);
         repeat (n) send_tick();
      end
   endtask

   task automatic send_frame(input logic [LENGTH_W-1:0] len, input bit good, input int fill);
      logic [BYTE_W-1:0] sum;
      logic [BYTE_W-1:0] v;
      int                i;
      sum = '0;
      send_byte(START_BYTE);
      safe_ticks();
      send_byte(len[15:8]);
      safe_ticks();
      send_byte(len[7:0]);
      safe_ticks();
      for (i = 0; i < int'(len); i++) begin
         case (fill)
            FILL_ZERO:  v = 8'h00;
            FILL_ONES:  v = 8'hFF;
            FILL_START: v = START_BYTE;
            default:    v = ($urandom_range(0, 7) == 0) ? START_BYTE : 8'($urandom);
         endcase
         send_byte(v);
         sum = sum + v;
         safe_ticks();
      end
      v = CHECK_BASE - sum;
      if (!good) v = v ^ (8'h01 << $urandom_range(0, 7));
      send_byte(v);
   endtask

   // A frame that stops partway and is then abandoned by exactly enough ticks.
   task automatic send_stalled_frame(input logic [LENGTH_W-1:0] len);
      int stage;
      int n;
      stage = $urandom_range(0, 3);
      send_byte(START_BYTE);
      if (stage >= 1) send_byte(len[15:8]);
      if (stage >= 2) send_byte(len[7:0]);
      if (stage == 3) begin
         n = $urandom_range(0, (int'(len) < 6) ? int'(len) : 6);
         repeat (n) send_byte(8'($urandom));
      end
      repeat (cur_timeout) send_tick();
      // The frame is gone, so this word must be ignored.
      send_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF);
   endtask

   task automatic send_noise();
      logic [BYTE_W-1:0] b;
      repeat ($urandom_range(1, 4)) begin
         b = 8'($urandom);
         if (b == START_BYTE) b = 8'h00;
         if ($urandom_range(0, 1) == 0) send_tick();
         else send_word(CMD_BYTE, b);
      end
   endtask

   task automatic set_timeout(input logic [TICKS_W-1:0] v);
      @(negedge clock);
      req.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_wen = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_wen = 1'b0;
      cur_timeout = int'(v);
   endtask

   task automatic random_run(input int words);
      int target;
      int pick;
      int len;
      target = frame_words + words;
      while (frame_words < target) begin
         calm = ($urandom_range(0, 5) == 0);
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 9))
            0:       len = 0;
            1, 2:    len = $urandom_range(17, 40);
            default: len = $urandom_range(1, 16);
         endcase
         if (pick < 65 || (pick < 85 && pick >= 75 && cur_timeout > 400))
            send_frame(16'(len), 1'b1, FILL_RANDOM);
         else if (pick < 75)
            send_frame(16'(len), 1'b0, FILL_RANDOM);
         else if (pick < 85)
            send_stalled_frame(16'($urandom));
         else
            send_noise();
      end
      calm = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_wen = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.cmd = CMD_BYTE;
      req.rx_byte = '0;
      calm = 1'b0;
      cur_timeout = int'(TIMEOUT_RESET);
      frame_words = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed checks at the reset timeout.
      send_tick();
      send_word(CMD_BYTE, 8'h00);
      send_word(CMD_BYTE, 8'hFF);
      send_frame(16'd0, 1'b1, FILL_RANDOM);
      send_frame(16'd0, 1'b0, FILL_RANDOM);
      send_frame(16'd1, 1'b1, FILL_START);
      send_frame(16'd16, 1'b1, FILL_ZERO);
      send_frame(16'd16, 1'b1, FILL_ONES);
      send_frame(16'd17, 1'b1, FILL_RANDOM);
      send_frame(16'd3, 1'b0, FILL_RANDOM);
      // Exactly at the timeout: the frame is abandoned and the stray word ignored.
      send_byte(START_BYTE);
      send_byte(8'h00);
      send_byte(8'h01);
      repeat (TIMEOUT_RESET) send_tick();
      send_byte(8'h00);
      send_frame(16'd2, 1'b1, FILL_RANDOM);

      set_timeout(SHORT_TIMEOUT);
      // One tick short of the timeout: the frame survives.
      send_byte(START_BYTE);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h12);
      repeat (SHORT_TIMEOUT - 1) send_tick();
      send_byte(8'h34);
      send_byte(CHECK_BASE - 8'h46);
      // Exactly at the short timeout.
      send_byte(START_BYTE);
      send_byte(8'h00);
      send_byte(8'h01);
      repeat (SHORT_TIMEOUT) send_tick();
      send_byte(8'h00);
      send_frame(16'd2, 1'b1, FILL_RANDOM);

      set_timeout(16'd1);
      random_run(30);

      set_timeout(16'hFFFF);
      random_run(30);

      set_timeout(16'($urandom_range(2, 12)));
      random_run(40);

      set_timeout(16'($urandom_range(13, 40)));
      random_run(40);

      @(negedge clock);
      req.valid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+src
src/afr_pkg.sv
src/afr_if.sv
src/afr_ram.sv
src/api_frame_receiver.sv
tb/afr_frame_checker.sv
tb/api_frame_receiver_test.sv
